FILE: src/mrdt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mrdt_pkg
// Shared types and constants for the multichannel reload down timer: the
// operation codes, register offsets, control word bit positions and the
// stream beat widths.
// ============================================================================
package mrdt_pkg;

    // Number of timer channels built by default.
    localparam int CHANNELS_DEFAULT = 6;

    // Stream beat widths; the data widths are padded up to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    // Channels shown on the pending output field.
    localparam int PEND_OUT_W = 6;

    // Kind of an input beat.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    // Register offsets within a channel's 16-byte window.
    localparam logic [3:0] OFF_CONTROL = 4'h4;
    localparam logic [3:0] OFF_RELOAD  = 4'h8;
    localparam logic [3:0] OFF_COUNT   = 4'hC;

    // Bit positions in the control word as seen on the bus.
    localparam int CW_EN   = 31;
    localparam int CW_FAST = 30;
    localparam int CW_IEN  = 27;
    localparam int CW_MID  = 25;
    localparam int CW_PWR  = 24;
    localparam int CW_FLAG = 0;

    // Stored control bits of one channel.
    typedef struct packed {
        logic en;
        logic fast;
        logic ien;
        logic mid;
        logic pwr;
        logic flag;
    } ctrl_t;

    // Builds the bus view of a channel's control bits.
    function automatic logic [31:0] ctrl_to_word(ctrl_t c);
        logic [31:0] w;
        w          = '0;
        w[CW_EN]   = c.en;
        w[CW_FAST] = c.fast;
        w[CW_IEN]  = c.ien;
        w[CW_MID]  = c.mid;
        w[CW_PWR]  = c.pwr;
        w[CW_FLAG] = c.flag;
        return w;
    endfunction

endpackage

FILE: src/multichannel_reload_down_timer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// multichannel_reload_down_timer_top
// Register-bus timer with several reload down counters, driven by a stream
// of tick, read and write beats and answering each with one result beat.
// ============================================================================
// Every input beat gives exactly one output beat. A beat is held in an input
// register, where the tick, read or write is applied to all channels at once
// by one pass of logic, and the result goes to an output register; so the
// block takes one beat per clock cycle unless the output stalls, and the
// result is offered from the output register. Both stages advance together
// only when the output register is free or being emptied.
// The result carries the register value for a read (zero otherwise) and the
// interrupt state after the beat's effect. Offsets: 0x00 status, then
// 0x04/0x08/0x0C + 16n for control, reload and count of channel n.
module multichannel_reload_down_timer_top
    #(
        parameter int CHANNELS = mrdt_pkg::CHANNELS_DEFAULT
    )
    (
        input  logic                             clk,
        input  logic                             rst_n,
        input  logic                             s_axis_tvalid,
        output logic                             s_axis_tready,
        // address[6:0], write_data[38:7], tick_fast[39], tick_mid[40],
        // tick_slow[41], zero padding[47:42]
        input  logic [mrdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
        // operation[1:0]
        input  logic [mrdt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
        output logic                             m_axis_tvalid,
        input  logic                             m_axis_tready,
        // read_data[31:0], irq_out[32], pending_bits[38:33], zero padding[39]
        output logic [mrdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
    );

    import mrdt_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline control and registers
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic [IN_TUSER_W-1:0] in_user_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_rdata_reg;
    logic                  out_irq_reg;
    logic [PEND_OUT_W-1:0] out_pend_reg;
    logic                  advance;

    // Channel state.
    ctrl_t       control_reg  [CHANNELS];
    logic [31:0] reload_reg   [CHANNELS];
    logic [31:0] count_reg    [CHANNELS];
    ctrl_t       control_next [CHANNELS];
    logic [31:0] reload_next  [CHANNELS];
    logic [31:0] count_next   [CHANNELS];

    // Decoded fields of the held beat.
    op_t         op;
    logic [6:0]  addr;
    logic [31:0] wdata;
    logic        tick_fast;
    logic        tick_mid;
    logic        tick_slow;
    logic [2:0]  chan;
    logic [3:0]  offset;
    logic        is_status;

    logic [CHANNELS-1:0] pend_now;
    logic [CHANNELS-1:0] pend_next;
    logic [7:0]          pend_wide;
    logic [31:0]         rdata_next;

    // A beat moves on when the output slot is free or is being taken.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign op        = op_t'(in_user_reg);
    assign addr      = in_data_reg[6:0];
    assign wdata     = in_data_reg[38:7];
    assign tick_fast = in_data_reg[39];
    assign tick_mid  = in_data_reg[40];
    assign tick_slow = in_data_reg[41];
    assign chan      = addr[6:4];
    assign offset    = addr[3:0];
    assign is_status = (addr == 7'd0);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Channel update: tick, control write and reload write
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int n = 0; n < CHANNELS; n++)
        begin
            control_next[n] = control_reg[n];
            reload_next[n]  = reload_reg[n];
            count_next[n]   = count_reg[n];
            unique case (op)
                OP_TICK:
                begin
                    if (control_reg[n].en && control_reg[n].pwr &&
                        (control_reg[n].fast ? tick_fast :
                         control_reg[n].mid  ? tick_mid  : tick_slow))
                    begin
                        if (count_reg[n] == 32'd0)
                        begin
                            control_next[n].flag = 1'b1;
                            count_next[n]        = reload_reg[n];
                        end
                        else
                        begin
                            count_next[n] = count_reg[n] - 32'd1;
                        end
                    end
                end
                OP_WRITE:
                begin
                    if (!is_status && chan == 3'(n))
                    begin
                        if (offset == OFF_CONTROL)
                        begin
                            control_next[n].en   = wdata[CW_EN];
                            control_next[n].fast = wdata[CW_FAST];
                            control_next[n].ien  = wdata[CW_IEN];
                            control_next[n].mid  = wdata[CW_MID];
                            control_next[n].pwr  = wdata[CW_PWR];
                            // Writing one to the flag clears it.
                            control_next[n].flag = control_reg[n].flag && !wdata[CW_FLAG];
                        end
                        else if (offset == OFF_RELOAD)
                        begin
                            reload_next[n] = wdata;
                            count_next[n]  = wdata;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pending bits before and after the beat's effect.
    always_comb
    begin
        for (int n = 0; n < CHANNELS; n++)
        begin
            pend_now[n]  = control_reg[n].flag && control_reg[n].ien;
            pend_next[n] = control_next[n].flag && control_next[n].ien;
        end
    end

    assign pend_wide = 8'(pend_next);

    // ------------------------------------------------------------------
    // Register read
    // ------------------------------------------------------------------
    always_comb
    begin
        rdata_next = '0;
        if (op == OP_READ)
        begin
            if (is_status)
            begin
                rdata_next = 32'(pend_now);
            end
            else
            begin
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (chan == 3'(n))
                    begin
                        unique case (offset)
                            OFF_CONTROL: rdata_next = ctrl_to_word(control_reg[n]);
                            OFF_RELOAD:  rdata_next = reload_reg[n];
                            OFF_COUNT:   rdata_next = count_reg[n];
                            default:     rdata_next = '0;
                        endcase
                    end
                end
            end
        end
    end

    // Channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                control_reg[n] <= '0;
                reload_reg[n]  <= '0;
                count_reg[n]   <= '0;
            end
        end
        else if (advance)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                control_reg[n] <= control_next[n];
                reload_reg[n]  <= reload_next[n];
                count_reg[n]   <= count_next[n];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rdata_reg <= rdata_next;
            out_irq_reg   <= |pend_next;
            out_pend_reg  <= pend_wide[PEND_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_pend_reg, out_irq_reg, out_rdata_reg};

endmodule

FILE: dv/multichannel_reload_down_timer_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// multichannel_reload_down_timer_top_tb
// Self-checking bench for the multichannel reload down timer. A queue of tick,
// read and write beats feeds a stream driver. Each accepted beat goes through
// a local timer predictor, and the result beat it should give is queued. A
// monitor compares every result beat field by field with the oldest entry.
// ============================================================================
module multichannel_reload_down_timer_top_tb;

    import mrdt_pkg::*;

    localparam int NCH          = CHANNELS_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Bus view of the control bits.
    localparam logic [31:0] W_EN   = 32'd1 << CW_EN;
    localparam logic [31:0] W_FAST = 32'd1 << CW_FAST;
    localparam logic [31:0] W_IEN  = 32'd1 << CW_IEN;
    localparam logic [31:0] W_MID  = 32'd1 << CW_MID;
    localparam logic [31:0] W_PWR  = 32'd1 << CW_PWR;
    localparam logic [31:0] W_FLAG = 32'd1 << CW_FLAG;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  addr;
        logic [31:0] wdata;
        logic        fast;
        logic        mid;
        logic        slow;
    } bus_beat_t;

    typedef struct packed {
        logic [31:0]           rdata;
        logic                  irq;
        logic [PEND_OUT_W-1:0] pend;
    } timer_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predicted timer state.
    ctrl_t       chan_ctrl   [NCH];
    logic [31:0] chan_reload [NCH];
    logic [31:0] chan_count  [NCH];

    bus_beat_t     pending_beats[$];
    timer_result_t due_results[$];
    bus_beat_t     cur_beat;
    timer_result_t oldest_due;

    int tx_idle_pct = 9;
    int rx_idle_pct = 54;
    int hold_req    = 0;
    int hold_left   = 0;
    int issued      = 0;
    int accepted    = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int n_ticks     = 0;
    int n_reads     = 0;
    int n_writes    = 0;
    int n_wraps     = 0;
    int n_irq_seen  = 0;

    multichannel_reload_down_timer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Applies one accepted beat to the predicted timer state and queues the
    // result beat it must produce.
    task automatic timer_predict(input bus_beat_t b);
        timer_result_t r;
        logic [31:0]   pend_word;
        logic [3:0]    off;
        logic          strobe;
        logic          mapped;
        int            ch;
        r      = '0;
        ch     = int'(b.addr[6:4]);
        off    = b.addr[3:0];
        mapped = (ch < NCH) && (off != 4'h0) && (off[1:0] == 2'b00);
        accepted++;
        case (b.op)
            OP_TICK:
            begin
                n_ticks++;
                for (int n = 0; n < NCH; n++)
                begin
                    if (chan_ctrl[n].fast)
                        strobe = b.fast;
                    else if (chan_ctrl[n].mid)
                        strobe = b.mid;
                    else
                        strobe = b.slow;
                    if (chan_ctrl[n].en && chan_ctrl[n].pwr && strobe)
                    begin
                        if (chan_count[n] == 32'd0)
                        begin
                            chan_ctrl[n].flag = 1'b1;
                            chan_count[n]     = chan_reload[n];
                            n_wraps++;
                        end
                        else
                            chan_count[n] = chan_count[n] - 32'd1;
                    end
                end
            end
            OP_READ:
            begin
                n_reads++;
                if (b.addr != 7'd0 && mapped)
                begin
                    case (off)
                        OFF_CONTROL:
                        begin
                            r.rdata[CW_EN]   = chan_ctrl[ch].en;
                            r.rdata[CW_FAST] = chan_ctrl[ch].fast;
                            r.rdata[CW_IEN]  = chan_ctrl[ch].ien;
                            r.rdata[CW_MID]  = chan_ctrl[ch].mid;
                            r.rdata[CW_PWR]  = chan_ctrl[ch].pwr;
                            r.rdata[CW_FLAG] = chan_ctrl[ch].flag;
                        end
                        OFF_RELOAD: r.rdata = chan_reload[ch];
                        default:    r.rdata = chan_count[ch];
                    endcase
                end
            end
            OP_WRITE:
            begin
                n_writes++;
                if (b.addr != 7'd0 && mapped)
                begin
                    if (off == OFF_CONTROL)
                    begin
                        // Writing one to the flag clears it; zero leaves it.
                        chan_ctrl[ch].flag = chan_ctrl[ch].flag & ~b.wdata[CW_FLAG];
                        chan_ctrl[ch].en   = b.wdata[CW_EN];
                        chan_ctrl[ch].fast = b.wdata[CW_FAST];
                        chan_ctrl[ch].ien  = b.wdata[CW_IEN];
                        chan_ctrl[ch].mid  = b.wdata[CW_MID];
                        chan_ctrl[ch].pwr  = b.wdata[CW_PWR];
                    end
                    else if (off == OFF_RELOAD)
                    begin
                        chan_reload[ch] = b.wdata;
                        chan_count[ch]  = b.wdata;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // Interrupt state after the beat's effect.
        pend_word = '0;
        for (int n = 0; n < NCH; n++)
            pend_word[n] = chan_ctrl[n].flag & chan_ctrl[n].ien;
        if (b.op == OP_READ && b.addr == 7'd0)
            r.rdata = pend_word;
        r.irq  = |pend_word;
        r.pend = pend_word[PEND_OUT_W-1:0];
        due_results.push_back(r);
    endtask

    function automatic logic [6:0] reg_addr(input int ch, input logic [3:0] off);
        logic [2:0] c;
        c = 3'(ch);
        return {c, off};
    endfunction

    task automatic push_beat(input logic [1:0] op, input logic [6:0] addr,
                             input logic [31:0] data, input logic f,
                             input logic m, input logic s);
        pending_beats.push_back('{op, addr, data, f, m, s});
        issued++;
    endtask

    // Random beats: mostly register traffic to live channels and ticks, with
    // some unmapped addresses and the unused operation as noise.
    task automatic push_random(input int count);
        bus_beat_t b;
        int        kind;
        int        pick;
        for (int i = 0; i < count; i++)
        begin
            b.addr  = 7'($urandom_range(0, 127));
            b.wdata = $urandom;
            b.fast  = 1'($urandom_range(0, 1));
            b.mid   = 1'($urandom_range(0, 1));
            b.slow  = 1'($urandom_range(0, 1));
            kind    = $urandom_range(0, 99);
            pick    = $urandom_range(0, 99);
            if (pick < 85)
                b.addr = reg_addr($urandom_range(0, NCH - 1), 4'($urandom_range(1, 3) * 4));
            else if (pick < 90)
                b.addr = 7'd0;
            if (kind < 40)
                b.op = OP_TICK;
            else if (kind < 65)
            begin
                b.op = OP_WRITE;
                if (b.addr[3:0] == OFF_CONTROL && $urandom_range(0, 3) != 0)
                    b.wdata = b.wdata | W_EN | W_PWR;
                else if (b.addr[3:0] == OFF_RELOAD && $urandom_range(0, 4) != 0)
                    b.wdata = $urandom_range(0, 12);
            end
            else if (kind < 95)
                b.op = OP_READ;
            else
                b.op = OP_UNUSED;
            pending_beats.push_back(b);
            issued++;
        end
    endtask

    task automatic wait_sent();
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (accepted != issued || due_results.size() != 0)
            @(posedge clk);
    endtask

    // Stream driver: a beat stays offered until taken; between beats the
    // sender may idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                timer_predict(cur_beat);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    cur_beat      = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, cur_beat.slow, cur_beat.mid, cur_beat.fast,
                                      cur_beat.wdata, cur_beat.addr};
                    s_axis_tuser  <= cur_beat.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left     = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result beat with none due, actual %h", $time, m_axis_tdata);
            end
            else
            begin
                oldest_due = due_results.pop_front();
                if (m_axis_tdata[32])
                    n_irq_seen++;
                if (m_axis_tdata[31:0] !== oldest_due.rdata)
                begin
                    err_count++;
                    $display("%0t: read_data expected %h actual %h",
                             $time, oldest_due.rdata, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[32] !== oldest_due.irq)
                begin
                    err_count++;
                    $display("%0t: irq_out expected %b actual %b",
                             $time, oldest_due.irq, m_axis_tdata[32]);
                end
                if (m_axis_tdata[38:33] !== oldest_due.pend)
                begin
                    err_count++;
                    $display("%0t: pending_bits expected %b actual %b",
                             $time, oldest_due.pend, m_axis_tdata[38:33]);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d of %0d beats accepted", accepted, issued);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int n = 0; n < NCH; n++)
        begin
            chan_ctrl[n]   = '0;
            chan_reload[n] = '0;
            chan_count[n]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Channel 0 has both selects set, so the fast strobe
        // rules; it wraps from zero and wraps again with its flag still set.
        push_beat(OP_READ,  7'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(0, OFF_RELOAD), 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(0, OFF_CONTROL), W_EN | W_FAST | W_MID | W_IEN | W_PWR,
                  1'b0, 1'b0, 1'b0);
        push_beat(OP_TICK,  7'd0, 32'd0, 1'b0, 1'b1, 1'b1);
        push_beat(OP_TICK,  7'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        push_beat(OP_TICK,  7'd0, 32'd0, 1'b1, 1'b1, 1'b1);
        push_beat(OP_READ,  reg_addr(0, OFF_CONTROL), 32'd0, 1'b0, 1'b0, 1'b0);
        // A zero in the flag bit leaves the flag set; all ones clears it.
        push_beat(OP_WRITE, reg_addr(0, OFF_CONTROL), W_EN | W_FAST | W_IEN | W_PWR,
                  1'b0, 1'b0, 1'b0);
        push_beat(OP_READ,  7'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(0, OFF_CONTROL), 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // Channel 5 on the middle strobe from the largest reload.
        push_beat(OP_WRITE, reg_addr(5, OFF_RELOAD), 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(5, OFF_CONTROL), W_EN | W_MID | W_IEN | W_PWR,
                  1'b0, 1'b0, 1'b0);
        push_beat(OP_TICK,  7'd0, 32'd0, 1'b0, 1'b1, 1'b0);
        push_beat(OP_READ,  reg_addr(5, OFF_COUNT), 32'd0, 1'b0, 1'b0, 1'b0);
        // Read-only registers ignore writes.
        push_beat(OP_WRITE, reg_addr(5, OFF_COUNT), 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // Channel 1 on the slow strobe, channel 2 enabled but unpowered.
        push_beat(OP_WRITE, reg_addr(1, OFF_RELOAD), 32'd1, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(1, OFF_CONTROL), W_EN | W_PWR | W_IEN | W_FLAG,
                  1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, reg_addr(2, OFF_CONTROL), W_EN | W_IEN, 1'b0, 1'b0, 1'b0);
        repeat (3)
            push_beat(OP_TICK, 7'd0, 32'd0, 1'b0, 1'b0, 1'b1);
        push_beat(OP_READ,  reg_addr(1, OFF_RELOAD), 32'd0, 1'b0, 1'b0, 1'b0);
        // Unmapped addresses and the unused operation.
        push_beat(OP_READ,  7'h64, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_WRITE, 7'h68, 32'h1234_5678, 1'b0, 1'b0, 1'b0);
        push_beat(OP_READ,  7'h7F, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_READ,  7'h10, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_READ,  7'h06, 32'd0, 1'b0, 1'b0, 1'b0);
        push_beat(OP_UNUSED, reg_addr(0, OFF_COUNT), 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // Light sender idling, heavy receiver stalls, and one long hold-off
        // while beats keep coming so the pipeline backs up.
        push_random(250);
        wait_sent();
        @(negedge clk);
        hold_req = LONG_HOLD;
        push_random(250);
        wait_drained();

        // Heavy sender idling, light receiver stalls.
        tx_idle_pct = 54;
        rx_idle_pct = 9;
        push_random(500);
        wait_drained();

        // Back to back.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random(500);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Ran %0d beats: %0d ticks with %0d counter wraps, %0d reads, %0d writes.",
                 accepted, n_ticks, n_wraps, n_reads, n_writes);
        $display("%0d results showed the interrupt raised; %0d mismatches.",
                 n_irq_seen, err_count);
        if (err_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
